// ===== design/u8d_pkg.sv =====
package u8d_pkg;

    localparam logic [7:0]  ASCII_MAX   = 8'h7F;
    localparam logic [1:0]  CONT_TAG    = 2'b10;
    localparam logic [31:0] SPACE_CHAR  = 32'h0000_0020;
    localparam int unsigned CP_W        = 32;

    typedef struct packed {
        logic [2:0]      pending;
        logic [2:0]      len_class;
        logic [CP_W-1:0] acc;
    } dec_state_t;

    typedef struct packed {
        logic            valid;
        logic [CP_W-1:0] code_point;
        logic            bad_sequence;
        logic            cut_short;
    } dec_result_t;

    localparam dec_state_t STATE_IDLE = '{pending: 3'd0, len_class: 3'd0, acc: '0};

    // trailing byte count from the low six bits of a lead byte
    function automatic logic [2:0] trail_count(input logic [5:0] lo);
        logic [2:0] n;
        if (lo < 6'd32)      n = 3'd1;
        else if (lo < 6'd48) n = 3'd2;
        else if (lo < 6'd56) n = 3'd3;
        else if (lo < 6'd60) n = 3'd4;
        else                 n = 3'd5;
        return n;
    endfunction

    // removes the lead-byte and continuation-tag bits folded into the sum
    function automatic logic [CP_W-1:0] length_offset(input logic [2:0] cls);
        logic [CP_W-1:0] off;
        case (cls)
            3'd1:    off = 32'h0000_3080;
            3'd2:    off = 32'h000E_2080;
            3'd3:    off = 32'h03C8_2080;
            3'd4:    off = 32'hFA08_2080;
            3'd5:    off = 32'h8208_2080;
            default: off = 32'h0000_0000;
        endcase
        return off;
    endfunction

endpackage

// ===== design/u8d_step.sv =====
module u8d_step (
    input  logic [7:0]           byte_in,
    input  logic                 last_in,
    input  u8d_pkg::dec_state_t  state_cur,
    output u8d_pkg::dec_state_t  state_nxt,
    output u8d_pkg::dec_result_t result
);

    logic [2:0]  lead_cls;
    logic [31:0] lead_acc;
    logic [31:0] sum;
    logic [31:0] sum_shifted;
    logic [2:0]  pend_dec;

    assign lead_cls    = u8d_pkg::trail_count(byte_in[5:0]);
    assign lead_acc    = {18'd0, byte_in, 6'd0};
    assign sum         = state_cur.acc + {24'd0, byte_in};
    assign sum_shifted = {sum[25:0], 6'd0};
    assign pend_dec    = state_cur.pending - 3'd1;

    always_comb begin
        state_nxt           = state_cur;
        result.valid        = 1'b0;
        result.code_point   = '0;
        result.bad_sequence = 1'b0;
        result.cut_short    = 1'b0;

        if (state_cur.pending == 3'd0) begin
            if (byte_in <= u8d_pkg::ASCII_MAX) begin
                result.valid      = 1'b1;
                result.code_point = {24'd0, byte_in};
            end else if (byte_in[7:6] == u8d_pkg::CONT_TAG) begin
                // continuation with no open sequence
                result.valid        = 1'b1;
                result.code_point   = u8d_pkg::SPACE_CHAR;
                result.bad_sequence = 1'b1;
            end else if (last_in) begin
                result.valid      = 1'b1;
                result.code_point = lead_acc - u8d_pkg::length_offset(lead_cls);
                result.cut_short  = 1'b1;
                state_nxt         = u8d_pkg::STATE_IDLE;
            end else begin
                state_nxt.pending   = lead_cls;
                state_nxt.len_class = lead_cls;
                state_nxt.acc       = lead_acc;
            end
        end else begin
            if (pend_dec == 3'd0) begin
                result.valid      = 1'b1;
                result.code_point = sum - u8d_pkg::length_offset(state_cur.len_class);
                state_nxt         = u8d_pkg::STATE_IDLE;
            end else if (last_in) begin
                result.valid      = 1'b1;
                result.code_point = sum_shifted
                                    - u8d_pkg::length_offset(state_cur.len_class);
                result.cut_short  = 1'b1;
                state_nxt         = u8d_pkg::STATE_IDLE;
            end else begin
                state_nxt.pending = pend_dec;
                state_nxt.acc     = sum_shifted;
            end
        end
    end

endmodule

// ===== design/utf8_byte_stream_decoder.sv =====
// Channel | Dir | tdata                  | tuser                          | tlast
// s_      | in  | [7:0] byte_in          | -                              | last_in
// m_      | out | [31:0] code_point      | [0] bad_sequence, [1] cut_short | -
//
// One byte per clock sustained while m_ is not stalled. A byte is held in the input
// register, decoded by the step logic, and its result lands in the result register
// that drives m_. Lead and non-final trailing bytes give no result. aresetn
// (synchronous) returns the decoder to idle and drops both stage valids. A stall
// on m_ holds the result register and the input register; s_tready falls only
// while both are occupied.
module utf8_byte_stream_decoder (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tlast,

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] code_point
    output logic [1:0]  m_tuser    // [0] bad_sequence, [1] cut_short
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_last_reg;

    u8d_pkg::dec_state_t  state_reg;
    u8d_pkg::dec_state_t  state_next;
    u8d_pkg::dec_result_t step_res;

    logic                 out_valid_reg;
    logic [31:0]          out_cp_reg;
    logic                 out_bad_reg;
    logic                 out_cut_reg;

    logic                 advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    u8d_step u_step (
        .byte_in   (in_byte_reg),
        .last_in   (in_last_reg),
        .state_cur (state_reg),
        .state_nxt (state_next),
        .result    (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= u8d_pkg::STATE_IDLE;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= step_res.valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && step_res.valid) begin
            out_cp_reg  <= step_res.code_point;
            out_bad_reg <= step_res.bad_sequence;
            out_cut_reg <= step_res.cut_short;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_cp_reg;
    assign m_tuser  = {out_cut_reg, out_bad_reg};

endmodule
